@@ rtl/rgb565_crop_downscale_luma_macros.svh @@
// Assertion macros shared by the RGB565 crop, downscale and luma block.
`ifndef RGB565_CROP_DOWNSCALE_LUMA_MACROS_SVH
`define RGB565_CROP_DOWNSCALE_LUMA_MACROS_SVH
`ifndef ASSERT_OFF
// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("%m: forbidden condition seen");
// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: implication failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rcdl_pkg.sv @@
// Types, constants and luma helper functions for the crop, downscale and luma block.
package rcdl_pkg;

	// Source frame geometry and line buffer size.
	localparam int SRC_WIDTH     = 320;
	localparam int SRC_HEIGHT    = 240;
	localparam int MAX_OUT_WIDTH = 128;

	// Configuration register widths and indexes.
	localparam int OW_W       = 8;
	localparam int OH_W       = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'b1;

	// Effective size limits of the output image.
	localparam int W_LIM = (MAX_OUT_WIDTH < SRC_WIDTH / 2) ? MAX_OUT_WIDTH : SRC_WIDTH / 2;
	localparam int H_LIM = SRC_HEIGHT / 2;

	// Counter and crop coordinate widths.
	localparam int COL_W = $clog2(SRC_WIDTH);
	localparam int ROW_W = $clog2(SRC_HEIGHT);
	localparam int CX_W  = $clog2(2 * W_LIM);
	localparam int CY_W  = $clog2(2 * H_LIM);
	localparam int IDX_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

	// Luma and pair sum widths.
	localparam int LUMA_W = 8;
	localparam int PAIR_W = 9;
	localparam int SUM_W  = 10;

	// Reciprocal constants for the truncating divisions by 31, 63 and 1000.
	localparam int RECIP31   = 8457;
	localparam int SH31      = 18;
	localparam int RECIP63   = 16645;
	localparam int SH63      = 20;
	localparam int RECIP1000 = 268436;
	localparam int SH1000    = 28;

	// Widths of the weighted channel terms.
	localparam int RT_W  = 17;
	localparam int GT_W  = 18;
	localparam int BT_W  = 15;
	localparam int WSUM_W = 18;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Port payloads.
	typedef struct packed {
		logic [15:0] pixel;
		logic        frame_start;
	} pix_in_t;

	typedef struct packed {
		logic signed [7:0] grey_value;
		logic              last_of_frame;
	} grey_out_t;

	// Configuration as seen by the front.
	typedef struct packed {
		logic [OW_W-1:0] out_width;
		logic [OH_W-1:0] out_height;
	} cfg_t;

	// What the back does with a kept pixel.
	typedef enum logic [1:0] {
		KIND_LEFT,
		KIND_STORE,
		KIND_EMIT
	} pix_kind_t;

	typedef struct packed {
		pix_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic             last;
	} pix_meta_t;

	typedef struct packed {
		logic [LUMA_W-1:0] luma;
		pix_meta_t         meta;
	} qitem_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	// Expands a 5-bit channel to 8 bits as c*255/31.
	function automatic logic [7:0] expand5(logic [4:0] c);
		logic [12:0] x;
		logic [26:0] p;
		x = 13'(c) * 13'd255;
		p = 27'(x) * 27'(RECIP31);
		return 8'(p >> SH31);
	endfunction

	// Expands a 6-bit channel to 8 bits as c*255/63.
	function automatic logic [7:0] expand6(logic [5:0] c);
		logic [13:0] x;
		logic [28:0] p;
		x = 14'(c) * 14'd255;
		p = 29'(x) * 29'(RECIP63);
		return 8'(p >> SH63);
	endfunction

	// Weighted channel terms of the luma sum.
	function automatic logic [RT_W-1:0] red_term(logic [4:0] r);
		return RT_W'(expand5(r)) * RT_W'(299);
	endfunction

	function automatic logic [GT_W-1:0] green_term(logic [5:0] g);
		return GT_W'(expand6(g)) * GT_W'(587);
	endfunction

	function automatic logic [BT_W-1:0] blue_term(logic [4:0] b);
		return BT_W'(expand5(b)) * BT_W'(114);
	endfunction

endpackage

@@ rtl/rcdl_front.sv @@
// Front part: raster counters, crop classification and the two-stage luma pipeline.
module rcdl_front import rcdl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_stall,
	input  pix_in_t in_data,
	input  logic    q_full,
	output logic    push,
	output qitem_t  push_item
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic              v_s1;
	logic [RT_W-1:0]   rterm_s1;
	logic [GT_W-1:0]   gterm_s1;
	logic [BT_W-1:0]   bterm_s1;
	pix_meta_t         meta_s1;

	logic              v_s2;
	logic [LUMA_W-1:0] luma_s2;
	pix_meta_t         meta_s2;

	logic              adv;
	logic              accept;
	logic [OW_W-1:0]   w_eff;
	logic [OH_W-1:0]   h_eff;
	logic [COL_W-1:0]  col_cur;
	logic [ROW_W-1:0]  row_cur;
	logic [COL_W:0]    x_lo;
	logic [COL_W:0]    x_hi;
	logic [ROW_W:0]    y_lo;
	logic [ROW_W:0]    y_hi;
	logic              in_crop;
	logic [CX_W-1:0]   cx;
	logic [CY_W-1:0]   cy;
	pix_meta_t         meta_nxt;
	logic [WSUM_W-1:0] wsum;
	logic [WSUM_W+18:0] wprod;

	// The pipeline moves unless its last stage holds a beat the queue cannot take.
	assign adv      = !v_s2 || !q_full;
	assign accept   = in_valid && adv;
	assign in_stall = !adv;
	assign push     = v_s2 && !q_full;
	assign push_item = '{luma: luma_s2, meta: meta_s2};

	// Effective output size, crop window and position of the current pixel.
	always_comb begin
		w_eff = cfg.out_width;
		if (cfg.out_width == '0) begin
			w_eff = OW_W'(1);
		end else if (cfg.out_width > OW_W'(W_LIM)) begin
			w_eff = OW_W'(W_LIM);
		end
		h_eff = cfg.out_height;
		if (cfg.out_height == '0) begin
			h_eff = OH_W'(1);
		end else if (cfg.out_height > OH_W'(H_LIM)) begin
			h_eff = OH_W'(H_LIM);
		end

		col_cur = in_data.frame_start ? '0 : col_q;
		row_cur = in_data.frame_start ? '0 : row_q;

		x_lo = (COL_W + 1)'(SRC_WIDTH / 2) - (COL_W + 1)'(w_eff);
		x_hi = x_lo + (COL_W + 1)'({w_eff, 1'b0});
		y_lo = (ROW_W + 1)'(SRC_HEIGHT / 2) - (ROW_W + 1)'(h_eff);
		y_hi = y_lo + (ROW_W + 1)'({h_eff, 1'b0});

		in_crop = ((COL_W + 1)'(col_cur) >= x_lo) && ((COL_W + 1)'(col_cur) < x_hi) &&
			((ROW_W + 1)'(row_cur) >= y_lo) && ((ROW_W + 1)'(row_cur) < y_hi);

		cx = CX_W'((COL_W + 1)'(col_cur) - x_lo);
		cy = CY_W'((ROW_W + 1)'(row_cur) - y_lo);

		// Even columns set the left luma, odd columns store or emit by row parity.
		if (!cx[0]) begin
			meta_nxt.kind = KIND_LEFT;
		end else if (!cy[0]) begin
			meta_nxt.kind = KIND_STORE;
		end else begin
			meta_nxt.kind = KIND_EMIT;
		end
		meta_nxt.idx  = IDX_W'(cx >> 1);
		meta_nxt.last = (cy == CY_W'({h_eff, 1'b0} - (OH_W + 1)'(1))) &&
			(cx == CX_W'({w_eff, 1'b0} - (OW_W + 1)'(1)));

		// Weighted sum divided by 1000 through its reciprocal.
		wsum  = WSUM_W'(rterm_s1) + WSUM_W'(gterm_s1) + WSUM_W'(bterm_s1);
		wprod = (WSUM_W + 19)'(wsum) * (WSUM_W + 19)'(RECIP1000);
	end

	// Raster counters and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (accept) begin
				if (col_cur == COL_W'(SRC_WIDTH - 1)) begin
					col_q <= '0;
					if (row_cur == ROW_W'(SRC_HEIGHT - 1)) begin
						row_q <= '0;
					end else begin
						row_q <= row_cur + ROW_W'(1);
					end
				end else begin
					col_q <= col_cur + COL_W'(1);
					row_q <= row_cur;
				end
			end
			if (adv) begin
				v_s1 <= accept && in_crop;
				v_s2 <= v_s1;
			end
		end
	end

	// Stage payloads: channel terms first, then the luma.
	always_ff @(posedge clk) begin
		if (adv) begin
			rterm_s1 <= red_term(in_data.pixel[15:11]);
			gterm_s1 <= green_term(in_data.pixel[10:5]);
			bterm_s1 <= blue_term(in_data.pixel[4:0]);
			meta_s1  <= meta_nxt;
			luma_s2  <= LUMA_W'(wprod >> SH1000);
			meta_s2  <= meta_s1;
		end
	end

endmodule

@@ rtl/rcdl_queue.sv @@
// Short FIFO of classified lumas between the front and the back.
module rcdl_queue import rcdl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  qitem_t    push_item,
	input  logic      pop,
	output qitem_t    head_item,
	output q_status_t stat
);

	qitem_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_item  = slot_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/rcdl_back.sv @@
// Back part: pairs lumas, keeps the line buffer of pair sums and forms output beats.
module rcdl_back import rcdl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qitem_t    head_item,
	input  logic      q_empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output grey_out_t out_data
);

	logic [PAIR_W-1:0] lbuf [MAX_OUT_WIDTH];

	logic [LUMA_W-1:0] left_q;
	logic              v_s1;
	logic [PAIR_W-1:0] pair_s1;
	logic [PAIR_W-1:0] above_s1;
	logic              last_s1;
	logic              out_valid_q;
	grey_out_t         out_q;

	logic              adv;
	logic [PAIR_W-1:0] pair;
	logic [SUM_W-1:0]  sum;

	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign pair = PAIR_W'(left_q) + PAIR_W'(head_item.luma);
	assign sum  = SUM_W'(above_s1) + SUM_W'(pair_s1);

	// Control: left luma, stage valid and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= 1'b0;
			out_valid_q <= v_s1;
			if (pop) begin
				unique case (head_item.meta.kind)
					KIND_LEFT: begin
						left_q <= head_item.luma;
					end
					KIND_STORE: begin
					end
					KIND_EMIT: begin
						v_s1 <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Line buffer port: one write or one registered read per beat.
	always_ff @(posedge clk) begin
		if (pop && head_item.meta.kind == KIND_STORE) begin
			lbuf[head_item.meta.idx] <= pair;
		end
		if (pop && head_item.meta.kind == KIND_EMIT) begin
			above_s1 <= lbuf[head_item.meta.idx];
			pair_s1  <= pair;
			last_s1  <= head_item.meta.last;
		end
	end

	// Output register: average of the block with the offset applied.
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_q.grey_value    <= $signed(LUMA_W'(sum >> 2) ^ 8'h80);
			out_q.last_of_frame <= last_s1;
		end
	end

endmodule

@@ rtl/rgb565_crop_downscale_luma.sv @@
// A block's result passes the front stages, the queue, the buffer read and output register.
// Throughput: one pixel beat per clock unless the queue is full (single line-buffer port).
// A four-entry queue lets input beats keep coming while grey is stalled, until it fills.
// Reset clears the counters, left luma, valids and queue; out_width and out_height go to 96.
// The pair-sum line buffer is not cleared and holds no value until its entries are written.
`include "rgb565_crop_downscale_luma_macros.svh"
module rgb565_crop_downscale_luma import rcdl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_in_t               pix,
	output logic                  grey_valid,
	input  logic                  grey_stall,
	output grey_out_t             grey,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      q_push;
	qitem_t    q_push_item;
	logic      q_pop;
	qitem_t    q_head;
	q_status_t q_stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_width  <= OW_W'(96);
			cfg_q.out_height <= OH_W'(96);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OUT_WIDTH:  cfg_q.out_width  <= OW_W'(cfg_data);
				CFG_OUT_HEIGHT: cfg_q.out_height <= OH_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	rcdl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (pix_valid),
		.in_stall  (pix_stall),
		.in_data   (pix),
		.q_full    (q_stat.full),
		.push      (q_push),
		.push_item (q_push_item)
	);

	rcdl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.head_item (q_head),
		.stat      (q_stat)
	);

	rcdl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (q_head),
		.q_empty   (q_stat.empty),
		.pop       (q_pop),
		.out_valid (grey_valid),
		.out_stall (grey_stall),
		.out_data  (grey)
	);

	// The queue never overfills, the front never pushes into a full queue,
	// and the input stalls only because the queue is full.
	`ASSERT_NEVER(a_queue_bound, clk, arst_n, q_stat.count > QCNT_W'(QDEPTH))
	`ASSERT_NEVER(a_push_full, clk, arst_n, q_push && q_stat.full)
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, pix_stall, q_stat.full)

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the RGB565 crop, 2x2 downscale and luma block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rcdl_pkg::*;

	// Frame geometry as the scoring logic sees it.
	localparam int unsigned FRAME_COLS = 320;
	localparam int unsigned FRAME_ROWS = 240;
	localparam int unsigned LINE_ENTRIES = 128;

	// Quiet time after the last expected beat, hold-off length and run limit.
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PRESSURE_HOLD = 300;
	localparam int unsigned CYCLE_LIMIT = 60_000;

	// Lengths of the random stretches around the directed rows.
	localparam int unsigned WARMUP_BEATS = 5;
	localparam int unsigned PRESSURE_BEATS = 140;
	localparam int unsigned CALM_BEATS = 110;

	// One row of the directed stimulus: filler pixels first, then the pixel itself.
	typedef struct packed {
		logic [15:0] lead;
		logic [15:0] px;
		logic        fs;
		logic        typed;
		logic [7:0]  grey;
		logic        last;
	} table_row_t;

	// Directed rows run with the clamped 256x240 crop, which starts at column 32 of row 0.
	// The top row stores six pairs, the second row emits their blocks.
	localparam table_row_t DIRECTED [25] = '{
		'{16'd0,   16'h0000, 1'b1, 1'b0, 8'h00, 1'b0},
		'{16'd31,  16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'hF800, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'hF800, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h07E0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h07E0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h001F, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h001F, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h8410, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h7BEF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd308, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'hFFFF, 1'b0, 1'b1, 8'h7F, 1'b0},
		'{16'd0,   16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h0000, 1'b0, 1'b1, 8'h80, 1'b0},
		'{16'd0,   16'hF800, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'hF800, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h07E0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h07E0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h001F, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h001F, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'h0001, 1'b0, 1'b0, 8'h00, 1'b0},
		'{16'd0,   16'hFFFE, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_stall;
	pix_in_t               pix;
	logic                  grey_valid;
	logic                  grey_stall;
	grey_out_t             grey;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predicted grey beats not yet seen on the output, oldest first.
	grey_out_t grey_due [$];
	grey_out_t grey_due_head;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit calm = 1'b0;
	bit pressure_armed = 1'b0;

	// Shadow of the block's scan position, line buffer and sizes.
	int unsigned scan_col = 0;
	int unsigned scan_row = 0;
	int unsigned held_luma = 0;
	logic [8:0] pair_line [LINE_ENTRIES];
	logic [7:0] size_w = 8'd96;
	logic [6:0] size_h = 7'd96;

	rgb565_crop_downscale_luma dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.grey_valid(grey_valid),
		.grey_stall(grey_stall),
		.grey(grey),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Effective output width after clamping the register.
	function automatic int unsigned crop_cols();
		int unsigned w;
		w = size_w;
		if (w < 1) w = 1;
		if (w > LINE_ENTRIES) w = LINE_ENTRIES;
		if (w > FRAME_COLS / 2) w = FRAME_COLS / 2;
		return w;
	endfunction

	// Effective output height after clamping the register.
	function automatic int unsigned crop_rows();
		int unsigned h;
		h = size_h;
		if (h < 1) h = 1;
		if (h > FRAME_ROWS / 2) h = FRAME_ROWS / 2;
		return h;
	endfunction

	// Luma of one RGB565 word, each channel widened to 8 bits first.
	function automatic int unsigned luma_of_rgb565(logic [15:0] px);
		int unsigned r8, g8, b8;
		r8 = px[15:11];
		g8 = px[10:5];
		b8 = px[4:0];
		r8 = r8 * 255 / 31;
		g8 = g8 * 255 / 63;
		b8 = b8 * 255 / 31;
		return (299 * r8 + 587 * g8 + 114 * b8) / 1000;
	endfunction

	// Advances the shadow state by one pixel beat and returns 1 if a grey beat is due.
	function automatic bit predict_grey(input pix_in_t beat, output grey_out_t res);
		int unsigned w, h, ox, oy, cx, cy, y, pair, idx, total;
		bit hit;
		hit = 1'b0;
		res = '0;
		w = crop_cols();
		h = crop_rows();
		ox = (FRAME_COLS - 2 * w) / 2;
		oy = (FRAME_ROWS - 2 * h) / 2;
		if (beat.frame_start) begin
			scan_col = 0;
			scan_row = 0;
		end
		if (scan_col >= ox && scan_col < ox + 2 * w && scan_row >= oy && scan_row < oy + 2 * h) begin
			cx = scan_col - ox;
			cy = scan_row - oy;
			y = luma_of_rgb565(beat.pixel);
			if (cx % 2 == 0) begin
				held_luma = y;
			end else begin
				pair = (held_luma + y) & 'h1FF;
				idx = (cx / 2) % LINE_ENTRIES;
				if (cy % 2 == 0) begin
					pair_line[idx] = pair[8:0];
				end else begin
					total = (((pair_line[idx] + pair) >> 2) ^ 'h80) & 'hFF;
					res.grey_value = total[7:0];
					res.last_of_frame = (cy == 2 * h - 1 && cx == 2 * w - 1);
					hit = 1'b1;
				end
			end
		end
		scan_col++;
		if (scan_col >= FRAME_COLS) begin
			scan_col = 0;
			scan_row++;
			if (scan_row >= FRAME_ROWS) scan_row = 0;
		end
		return hit;
	endfunction

	// Random pixel word, with the all-dark and all-bright words now and then.
	function automatic logic [15:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offers one pixel beat, waits for it to be taken and records its grey beat, if any.
	task automatic send_beat(input logic [15:0] px, input logic fs, input bit typed,
			input grey_out_t want);
		pix_in_t beat;
		grey_out_t res;
		beat.pixel = px;
		beat.frame_start = fs;
		if (!calm && $urandom_range(0, 7) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		pix <= beat;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		if (predict_grey(beat, res)) grey_due.push_back(typed ? want : res);
	endtask

	// Sends a run of random pixel beats without a frame start.
	task automatic stream_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++)
			send_beat(random_pixel(), 1'b0, 1'b0, '0);
	endtask

	// Stops offering beats and waits until the block has gone quiet.
	task automatic settle();
		pix_valid <= 1'b0;
		while (grey_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both size registers while the block is idle.
	task automatic resize(input logic [7:0] w, input logic [6:0] h);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_OUT_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_OUT_HEIGHT;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		size_w = w;
		size_h = h;
	endtask

	// Main stimulus: a few beats at the reset sizes, directed rows, then random beats.
	initial begin
		foreach (pair_line[i]) pair_line[i] = '0;
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		pix <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_OUT_WIDTH;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset sizes put these first pixels outside the crop.
		stream_random(WARMUP_BEATS);

		// Out-of-range sizes clamp to the largest crop; the table opens with an early
		// frame start.
		resize(8'd255, 7'd127);
		foreach (DIRECTED[i]) begin
			repeat (DIRECTED[i].lead) send_beat(random_pixel(), 1'b0, 1'b0, '0);
			send_beat(DIRECTED[i].px, DIRECTED[i].fs, DIRECTED[i].typed,
				{DIRECTED[i].grey, DIRECTED[i].last});
		end

		// Long output hold-off while the second crop row keeps the input busy.
		pressure_armed = 1'b1;
		stream_random(PRESSURE_BEATS);

		// Closing stretch runs without idling on either side.
		calm = 1'b1;
		stream_random(CALM_BEATS);

		settle();
		if (mismatches == 0 && grey_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Output side: random stall bursts and one long hold-off on request.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		grey_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0) begin
				if (pressure_armed && grey_valid) begin
					hold_left = PRESSURE_HOLD;
					pressure_armed = 1'b0;
				end else if (!calm && $urandom_range(0, 11) == 0) begin
					hold_left = $urandom_range(1, 8);
				end
			end
			if (hold_left != 0) begin
				grey_stall <= 1'b1;
				hold_left--;
			end else begin
				grey_stall <= 1'b0;
			end
		end
	end

	// Compare every accepted grey beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && grey_valid && !grey_stall) begin
			if (grey_due.size() == 0) begin
				$display("%0t: grey beat with none due: grey %0d last %0b", $time,
					grey.grey_value, grey.last_of_frame);
				mismatches++;
			end else begin
				grey_due_head = grey_due.pop_front();
				if (grey.grey_value !== grey_due_head.grey_value) begin
					$display("%0t: grey_value expected %0d actual %0d", $time,
						grey_due_head.grey_value, grey.grey_value);
					mismatches++;
				end
				if (grey.last_of_frame !== grey_due_head.last_of_frame) begin
					$display("%0t: last_of_frame expected %0b actual %0b", $time,
						grey_due_head.last_of_frame, grey.last_of_frame);
					mismatches++;
				end
			end
		end
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
